// ----- design/crd_pkg.sv -----
package crd_pkg;

   localparam int ScreenWidth = 16;
   localparam int ScaleWidth  = 15;
   localparam int RotWidth    = 48;
   localparam int WeightWidth = 16;
   localparam int OutWidth    = 16;
   localparam int CsrIdxWidth = 3;
   localparam int CsrDataWidth = 48;
   localparam int AngleMax    = 25736;
   localparam int TableLen    = 24;
   localparam int CordicStepsDefault = 16;
   localparam int CordicWidth = 28;
   localparam logic signed [CordicWidth-1:0] CordicGain = 28'sd10188014;
   localparam int OutMax      = 16384;

   localparam logic [CsrIdxWidth-1:0] RegHorizScale = 3'd0;
   localparam logic [CsrIdxWidth-1:0] RegVertScale  = 3'd1;
   localparam logic [CsrIdxWidth-1:0] RegRotToX     = 3'd2;
   localparam logic [CsrIdxWidth-1:0] RegRotToY     = 3'd3;
   localparam logic [CsrIdxWidth-1:0] RegRotToZ     = 3'd4;

   localparam logic [ScaleWidth-1:0] HorizScaleReset = 15'd9060;
   localparam logic [ScaleWidth-1:0] VertScaleReset  = 15'd3939;
   localparam logic [RotWidth-1:0]   RotToXReset = 48'h0000_0000_4000;
   localparam logic [RotWidth-1:0]   RotToYReset = 48'h0000_4000_0000;
   localparam logic [RotWidth-1:0]   RotToZReset = 48'h4000_0000_0000;

   typedef struct packed {
      logic signed [CordicWidth-1:0] x;
      logic signed [CordicWidth-1:0] y;
      logic signed [CordicWidth-1:0] z;
   } cordic_vec_type;

   function automatic logic signed [CordicWidth-1:0] atan_entry(input int i);
      logic signed [CordicWidth-1:0] v;
      case (i)
         0: v = 28'sd13176795;
         1: v = 28'sd7778716;
         2: v = 28'sd4110060;
         3: v = 28'sd2086331;
         4: v = 28'sd1047214;
         5: v = 28'sd524117;
         6: v = 28'sd262123;
         7: v = 28'sd131069;
         default: v = (i < TableLen) ? (28'sd1 <<< (24 - i)) : 28'sd0;
      endcase
      return v;
   endfunction

endpackage

// ----- design/crd_angle.sv -----
module crd_angle (
   input  logic clock,
   input  logic reset,
   input  logic stall,
   input  logic in_valid,
   input  logic [crd_pkg::ScreenWidth-1:0] screen_x,
   input  logic [crd_pkg::ScreenWidth-1:0] screen_y,
   input  logic [crd_pkg::ScaleWidth-1:0]  horiz_scale,
   input  logic [crd_pkg::ScaleWidth-1:0]  vert_scale,
   output logic out_valid,
   output logic signed [crd_pkg::CordicWidth-1:0] theta,
   output logic signed [crd_pkg::CordicWidth-1:0] phi
);
   // frac (18b signed) times scale (16b) = 34b product, round to 2^-24
   logic signed [17:0] fx_in, fy_in;
   logic signed [15:0] hs_in, vs_in;
   logic signed [33:0] pt_in, pp_in;
   logic valid_ff;
   logic signed [crd_pkg::CordicWidth-1:0] theta_ff, phi_ff;

   always_comb begin
      fx_in = $signed({1'b0, screen_x, 1'b0}) - 18'sd65536;
      fy_in = 18'sd65536 - $signed({1'b0, screen_y, 1'b0});
      hs_in = (horiz_scale > 15'(crd_pkg::AngleMax)) ?
              16'(crd_pkg::AngleMax) : $signed({1'b0, horiz_scale});
      vs_in = (vert_scale > 15'(crd_pkg::AngleMax)) ?
              16'(crd_pkg::AngleMax) : $signed({1'b0, vert_scale});
      pt_in = 34'(fy_in) * 34'(vs_in) + 34'sd32;
      pp_in = 34'(fx_in) * 34'(hs_in) + 34'sd32;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!stall) begin
         valid_ff <= in_valid;
      end
      if (!stall) begin
         theta_ff <= 28'(pt_in >>> 6);
         phi_ff   <= 28'(pp_in >>> 6);
      end
   end

   assign out_valid = valid_ff;
   assign theta = theta_ff;
   assign phi = phi_ff;
endmodule

// ----- design/crd_cordic.sv -----
module crd_cordic #(
   parameter int CORDIC_STEPS = crd_pkg::CordicStepsDefault
) (
   input  logic clock,
   input  logic reset,
   input  logic stall,
   input  logic in_valid,
   input  logic signed [crd_pkg::CordicWidth-1:0] theta,
   input  logic signed [crd_pkg::CordicWidth-1:0] phi,
   output logic out_valid,
   output crd_pkg::cordic_vec_type res_t,
   output crd_pkg::cordic_vec_type res_p
);
   localparam int Steps = (CORDIC_STEPS < crd_pkg::TableLen) ?
                          CORDIC_STEPS : crd_pkg::TableLen;

   crd_pkg::cordic_vec_type t_ff [Steps+1];
   crd_pkg::cordic_vec_type p_ff [Steps+1];
   logic [Steps:0] valid_ff;

   function automatic crd_pkg::cordic_vec_type rotate(
      input crd_pkg::cordic_vec_type v, input int i);
      crd_pkg::cordic_vec_type r;
      logic signed [crd_pkg::CordicWidth-1:0] dx, dy;
      dx = v.y >>> i;
      dy = v.x >>> i;
      if (!v.z[crd_pkg::CordicWidth-1]) begin
         r.x = v.x - dx; r.y = v.y + dy; r.z = v.z - crd_pkg::atan_entry(i);
      end else begin
         r.x = v.x + dx; r.y = v.y - dy; r.z = v.z + crd_pkg::atan_entry(i);
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (!stall) begin
         valid_ff <= {valid_ff[Steps-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         t_ff[0] <= '{x: crd_pkg::CordicGain, y: '0, z: theta};
         p_ff[0] <= '{x: crd_pkg::CordicGain, y: '0, z: phi};
      end
   end

   for (genvar g = 0; g < Steps; g++) begin : g_step
      always_ff @(posedge clock) begin
         if (!stall) begin
            t_ff[g+1] <= rotate(t_ff[g], g);
            p_ff[g+1] <= rotate(p_ff[g], g);
         end
      end
   end

   assign out_valid = valid_ff[Steps];
   assign res_t = t_ff[Steps];
   assign res_p = p_ff[Steps];
endmodule

// ----- design/crd_rotate.sv -----
module crd_rotate (
   input  logic clock,
   input  logic reset,
   input  logic stall,
   input  logic in_valid,
   input  crd_pkg::cordic_vec_type res_t,
   input  crd_pkg::cordic_vec_type res_p,
   input  logic [crd_pkg::RotWidth-1:0] rot_x,
   input  logic [crd_pkg::RotWidth-1:0] rot_y,
   input  logic [crd_pkg::RotWidth-1:0] rot_z,
   output logic out_valid,
   output logic [3*crd_pkg::OutWidth-1:0] dir
);
   localparam int W = crd_pkg::CordicWidth;
   // stage A: local direction products
   logic signed [2*W-1:0] sp_in, cp_in;
   logic signed [W-1:0] d0_ff, d1_ff, d2_ff;
   // stage B: weight products
   logic signed [W+15:0] prod_ff [3][3];
   // stage C: sum, round, saturate
   logic signed [W+17:0] acc_in [3];
   logic signed [W+17:0] rnd_in [3];
   logic [crd_pkg::OutWidth-1:0] out_ff [3];
   logic [2:0] valid_ff;
   logic [crd_pkg::RotWidth-1:0] rot_in [3];

   assign sp_in = res_t.x * res_p.y + (56'sd1 <<< 23);
   assign cp_in = res_t.x * res_p.x + (56'sd1 <<< 23);
   assign rot_in[0] = rot_x;
   assign rot_in[1] = rot_y;
   assign rot_in[2] = rot_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (!stall) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         d0_ff <= W'(sp_in >>> 24);
         d1_ff <= -res_t.y;
         d2_ff <= W'(cp_in >>> 24);
      end
   end

   for (genvar r = 0; r < 3; r++) begin : g_row
      always_ff @(posedge clock) begin
         if (!stall) begin
            prod_ff[r][0] <= $signed(rot_in[r][15:0])  * d0_ff;
            prod_ff[r][1] <= $signed(rot_in[r][31:16]) * d1_ff;
            prod_ff[r][2] <= $signed(rot_in[r][47:32]) * d2_ff;
         end
      end
      always_comb begin
         acc_in[r] = (W+18)'(prod_ff[r][0]) + (W+18)'(prod_ff[r][1])
                   + (W+18)'(prod_ff[r][2]);
         rnd_in[r] = (acc_in[r] + ((W+18)'(1) <<< 23)) >>> 24;
      end
      always_ff @(posedge clock) begin
         if (!stall) begin
            if (rnd_in[r] > (W+18)'(crd_pkg::OutMax))
               out_ff[r] <= 16'(crd_pkg::OutMax);
            else if (rnd_in[r] < -(W+18)'(crd_pkg::OutMax))
               out_ff[r] <= -16'(crd_pkg::OutMax);
            else
               out_ff[r] <= rnd_in[r][15:0];
         end
      end
   end

   assign out_valid = valid_ff[2];
   assign dir = {out_ff[2], out_ff[1], out_ff[0]};
endmodule

// ----- design/camera_ray_direction.sv -----
// Channel  Dir  Payload (low bit first)
// req_     in   tdata: screen_x[15:0], screen_y[31:16]
// rsp_     out  tdata: dir_x[15:0], dir_y[31:16], dir_z[47:32]
// csr_     in   index 0..4, data up to 48 bits
// One item per cycle while the output is not stalled; the pipeline has
// one angle stage, one CORDIC load stage, one register per CORDIC iteration
// (CORDIC_STEPS, capped at 24) and three stages in the rotator.
// Reset (synchronous) clears valid bits and loads register defaults.
// A stalled output freezes the whole pipeline; nothing is dropped.
module camera_ray_direction #(
   parameter int CORDIC_STEPS = crd_pkg::CordicStepsDefault
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [31:0] req_tdata,   // screen_x, screen_y
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [47:0] rsp_tdata,   // dir_x, dir_y, dir_z
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [crd_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [crd_pkg::CsrDataWidth-1:0] csr_data
);
   logic [crd_pkg::ScaleWidth-1:0] hs_ff, vs_ff;
   logic [crd_pkg::RotWidth-1:0] rx_ff, ry_ff, rz_ff;
   logic stall;
   logic a_valid, c_valid;
   logic signed [crd_pkg::CordicWidth-1:0] theta, phi;
   crd_pkg::cordic_vec_type res_t, res_p;

   assign stall = rsp_tvalid && !rsp_tready;
   assign req_tready = !stall;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hs_ff <= crd_pkg::HorizScaleReset;
         vs_ff <= crd_pkg::VertScaleReset;
         rx_ff <= crd_pkg::RotToXReset;
         ry_ff <= crd_pkg::RotToYReset;
         rz_ff <= crd_pkg::RotToZReset;
      end else if (csr_valid) begin
         case (csr_index)
            crd_pkg::RegHorizScale: hs_ff <= csr_data[crd_pkg::ScaleWidth-1:0];
            crd_pkg::RegVertScale:  vs_ff <= csr_data[crd_pkg::ScaleWidth-1:0];
            crd_pkg::RegRotToX:     rx_ff <= csr_data;
            crd_pkg::RegRotToY:     ry_ff <= csr_data;
            crd_pkg::RegRotToZ:     rz_ff <= csr_data;
            default: ;
         endcase
      end
   end

   crd_angle u_angle (
      .clock, .reset, .stall,
      .in_valid(req_tvalid),
      .screen_x(req_tdata[15:0]), .screen_y(req_tdata[31:16]),
      .horiz_scale(hs_ff), .vert_scale(vs_ff),
      .out_valid(a_valid), .theta, .phi
   );

   crd_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock, .reset, .stall,
      .in_valid(a_valid), .theta, .phi,
      .out_valid(c_valid), .res_t, .res_p
   );

   crd_rotate u_rotate (
      .clock, .reset, .stall,
      .in_valid(c_valid), .res_t, .res_p,
      .rot_x(rx_ff), .rot_y(ry_ff), .rot_z(rz_ff),
      .out_valid(rsp_tvalid), .dir(rsp_tdata)
   );

   assert property (@(posedge clock) disable iff (reset)
      stall |=> $stable(rsp_tdata))
      else $error("output changed during stall");
   assert property (@(posedge clock) disable iff (reset)
      req_tready == !(rsp_tvalid && !rsp_tready))
      else $error("ready does not follow stall");
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[15:0]) <= 16'sd16384
                   && $signed(rsp_tdata[15:0]) >= -16'sd16384))
      else $error("dir_x out of range");
endmodule
